// ===== design/cat_pkg.sv =====
// ----------------------------------------------------------------------------
// cat_pkg - shared types and constants of the connection anchor tracker
// Configuration layout, register indexes, action codes and the transaction
// structs passed between the tracker modules.
// ----------------------------------------------------------------------------
package cat_pkg;

    // field widths
    localparam int unsigned TimeW     = 32;
    localparam int unsigned CountW    = 16;
    localparam int unsigned IntervalW = 26;
    localparam int unsigned SupW      = 29;
    localparam int unsigned EpsW      = 10;
    localparam int unsigned WarmW     = 17;
    localparam int unsigned IfsW      = 17;
    localparam int unsigned WindowW   = 20;
    localparam int unsigned PktCntW   = 2;

    // apb register map
    localparam int unsigned AddrW     = 5;
    localparam int unsigned IdxW      = 3;
    localparam int unsigned DataW     = 32;

    localparam logic [IdxW-1:0] REG_EVT_PERIOD  = 3'd0;
    localparam logic [IdxW-1:0] REG_SUP_TIMEOUT = 3'd1;
    localparam logic [IdxW-1:0] REG_ANCHOR_TOL  = 3'd2;
    localparam logic [IdxW-1:0] REG_RX_WARMUP   = 3'd3;
    localparam logic [IdxW-1:0] REG_GAP_WAIT    = 3'd4;
    localparam logic [IdxW-1:0] REG_OPEN_WINDOW = 3'd5;

    // register reset values
    localparam logic [IntervalW-1:0] RST_EVT_PERIOD  = '0;
    localparam logic [SupW-1:0]      RST_SUP_TIMEOUT = '0;
    localparam logic [EpsW-1:0]      RST_ANCHOR_TOL  = 10'd30;
    localparam logic [WarmW-1:0]     RST_RX_WARMUP   = 17'd3000;
    localparam logic [IfsW-1:0]      RST_GAP_WAIT    = 17'd3000;
    localparam logic [WindowW-1:0]   RST_OPEN_WINDOW = 20'd24200;

    // packets seen in one event
    localparam logic [PktCntW-1:0] PKT_NONE = 2'd0;
    localparam logic [PktCntW-1:0] PKT_ONE  = 2'd1;
    localparam logic [PktCntW-1:0] PKT_TWO  = 2'd2;

    // input mode codes
    localparam logic MODE_PACKET = 1'b0;
    localparam logic MODE_TIMER  = 1'b1;

    typedef enum logic [1:0] {
        ACT_ARM_IFS    = 2'd0,
        ACT_OPEN_HOP   = 2'd1,
        ACT_NEXT_EVENT = 2'd2,
        ACT_LINK_DROP  = 2'd3
    } t_action;

    typedef struct packed {
        logic [IntervalW-1:0] evt_period;
        logic [SupW-1:0]      loss_limit;
        logic [EpsW-1:0]      anchor_tol;
        logic [WarmW-1:0]     rx_warmup;
        logic [IfsW-1:0]      gap_wait;
        logic [WindowW-1:0]   open_window;
    } t_cfg;

    typedef struct packed {
        logic             mode;
        logic [TimeW-1:0] packet_time;
        logic [TimeW-1:0] now;
        logic             cancel_request;
    } t_in_item;

    typedef struct packed {
        t_action           action;
        logic [TimeW-1:0]  match_time;
        logic [CountW-1:0] event_counter;
        logic              anchor_locked;
    } t_result;

endpackage

// ===== design/cat_in_if.sv =====
// ----------------------------------------------------------------------------
// cat_in_if - event input channel
// Valid/ready channel carrying one packet-end or timer-match event.
// ----------------------------------------------------------------------------
interface cat_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] packet_time;
    logic [31:0] now;
    logic        cancel_request;

    modport source (output valid, output mode, output packet_time, output now,
                    output cancel_request, input ready);
    modport sink   (input valid, input mode, input packet_time, input now,
                    input cancel_request, output ready);
endinterface

// ===== design/cat_out_if.sv =====
// ----------------------------------------------------------------------------
// cat_out_if - result output channel
// Valid/ready channel carrying one timing result per event.
// ----------------------------------------------------------------------------
interface cat_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] match_time;
    logic [15:0] event_counter;
    logic        anchor_locked;

    modport source (output valid, output action, output match_time,
                    output event_counter, output anchor_locked, input ready);
    modport sink   (input valid, input action, input match_time,
                    input event_counter, input anchor_locked, output ready);
endinterface

// ===== design/cat_cfg.sv =====
// ----------------------------------------------------------------------------
// cat_cfg - configuration register file
// APB slave holding the six timing registers, zero wait states.
// ----------------------------------------------------------------------------
module cat_cfg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output cat_pkg::t_cfg        o_cfg
);
    import cat_pkg::*;

    t_cfg              r_cfg;
    logic              wr_en;
    logic [IdxW-1:0]   reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[AddrW-1:2];
    assign o_cfg   = r_cfg;

    // register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.evt_period  <= RST_EVT_PERIOD;
            r_cfg.loss_limit  <= RST_SUP_TIMEOUT;
            r_cfg.anchor_tol  <= RST_ANCHOR_TOL;
            r_cfg.rx_warmup   <= RST_RX_WARMUP;
            r_cfg.gap_wait    <= RST_GAP_WAIT;
            r_cfg.open_window <= RST_OPEN_WINDOW;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_EVT_PERIOD:  r_cfg.evt_period  <= pwdata[IntervalW-1:0];
                REG_SUP_TIMEOUT: r_cfg.loss_limit  <= pwdata[SupW-1:0];
                REG_ANCHOR_TOL:  r_cfg.anchor_tol  <= pwdata[EpsW-1:0];
                REG_RX_WARMUP:   r_cfg.rx_warmup   <= pwdata[WarmW-1:0];
                REG_GAP_WAIT:    r_cfg.gap_wait    <= pwdata[IfsW-1:0];
                REG_OPEN_WINDOW: r_cfg.open_window <= pwdata[WindowW-1:0];
                default: ;
            endcase
        end
    end

    // register read
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_EVT_PERIOD:  prdata = {{(DataW-IntervalW){1'b0}}, r_cfg.evt_period};
            REG_SUP_TIMEOUT: prdata = {{(DataW-SupW){1'b0}}, r_cfg.loss_limit};
            REG_ANCHOR_TOL:  prdata = {{(DataW-EpsW){1'b0}}, r_cfg.anchor_tol};
            REG_RX_WARMUP:   prdata = {{(DataW-WarmW){1'b0}}, r_cfg.rx_warmup};
            REG_GAP_WAIT:    prdata = {{(DataW-IfsW){1'b0}}, r_cfg.gap_wait};
            REG_OPEN_WINDOW: prdata = {{(DataW-WindowW){1'b0}}, r_cfg.open_window};
            default:         prdata = '0;
        endcase
    end

endmodule

// ===== design/cat_core.sv =====
// ----------------------------------------------------------------------------
// cat_core - connection event state and update logic
// Holds the link timing state and computes the result for the event sitting
// in the input register; state moves on when that event advances.
// ----------------------------------------------------------------------------
module cat_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  cat_pkg::t_in_item    i_item,
    input  cat_pkg::t_cfg        i_cfg,
    output cat_pkg::t_result     o_result
);
    import cat_pkg::*;

    // link state
    logic [TimeW-1:0]   r_last_anchor,  n_last_anchor;
    logic               r_anchor_known, n_anchor_known;
    logic [TimeW-1:0]   r_last_pkt,     n_last_pkt;
    logic [CountW-1:0]  r_event_count,  n_event_count;
    logic [PktCntW-1:0] r_pkts,         n_pkts;
    logic [TimeW-1:0]   r_event_anchor, n_event_anchor;
    logic               r_event_open,   n_event_open;

    logic               is_packet;
    logic [PktCntW-1:0] pkts_inc;
    logic               do_close;
    logic [PktCntW-1:0] close_pkts;
    logic [TimeW-1:0]   ci_ext;
    logic [TimeW-1:0]   est;
    logic [TimeW-1:0]   dev;
    logic [EpsW:0]      twice_eps;
    logic               in_window;
    logic               accept;
    logic               take_event;
    logic [TimeW-1:0]   close_anchor;
    logic [TimeW-1:0]   close_last_pkt;
    logic [TimeW-1:0]   gap;
    logic               drop;
    logic [TimeW-1:0]   sched_from_event;
    logic [TimeW-1:0]   sched_from_est;
    logic [CountW-1:0]  count_inc;

    // event classification
    assign is_packet  = (i_item.mode == MODE_PACKET);
    assign pkts_inc   = r_pkts + PKT_ONE;
    assign do_close   = is_packet ? (pkts_inc >= PKT_TWO) : r_event_open;
    assign close_pkts = is_packet ? PKT_TWO : r_pkts;

    // anchor estimate and deviation window
    assign ci_ext    = {{(TimeW-IntervalW){1'b0}}, i_cfg.evt_period};
    assign est       = r_last_anchor + ci_ext;
    assign dev       = est - r_event_anchor
                     + {{(TimeW-EpsW){1'b0}}, i_cfg.anchor_tol};
    assign twice_eps = {i_cfg.anchor_tol, 1'b0};
    assign in_window = dev < {{(TimeW-EpsW-1){1'b0}}, twice_eps};
    assign accept    = (close_pkts == PKT_TWO)
                     | ((close_pkts == PKT_ONE) & r_anchor_known & in_window);

    // anchor taken from the event unless it is estimated
    assign take_event     = accept | ~r_anchor_known;
    assign close_anchor   = take_event ? r_event_anchor : est;
    assign close_last_pkt = ((~accept & ~r_anchor_known) | (close_pkts != PKT_NONE))
                          ? i_item.now : r_last_pkt;

    // supervision check
    assign gap  = i_item.now - close_last_pkt;
    assign drop = (gap > {{(TimeW-SupW){1'b0}}, i_cfg.loss_limit})
                | i_item.cancel_request;

    // next match for a scheduled event, both anchor choices in parallel
    assign sched_from_event = r_event_anchor + ci_ext
                            - {{(TimeW-WarmW){1'b0}}, i_cfg.rx_warmup};
    assign sched_from_est   = est + ci_ext
                            - {{(TimeW-WarmW){1'b0}}, i_cfg.rx_warmup};
    assign count_inc        = r_event_count + 1'b1;

    // next state and result
    always_comb begin
        n_last_anchor  = r_last_anchor;
        n_anchor_known = r_anchor_known;
        n_last_pkt     = r_last_pkt;
        n_event_count  = r_event_count;
        n_pkts         = r_pkts;
        n_event_anchor = r_event_anchor;
        n_event_open   = r_event_open;

        o_result.action        = ACT_ARM_IFS;
        o_result.match_time    = '0;
        o_result.event_counter = r_event_count;
        o_result.anchor_locked = r_anchor_known;

        if (do_close) begin
            n_pkts       = PKT_NONE;
            n_event_open = 1'b0;
            if (drop) begin
                n_last_anchor  = '0;
                n_anchor_known = 1'b0;
                n_last_pkt     = '0;
                n_event_count  = '0;
                o_result.action        = ACT_LINK_DROP;
                o_result.match_time    = '0;
                o_result.event_counter = '0;
                o_result.anchor_locked = 1'b0;
            end else begin
                n_last_anchor  = close_anchor;
                n_anchor_known = accept | r_anchor_known;
                n_last_pkt     = close_last_pkt;
                n_event_count  = count_inc;
                o_result.action        = ACT_NEXT_EVENT;
                o_result.match_time    = take_event ? sched_from_event : sched_from_est;
                o_result.event_counter = count_inc;
                o_result.anchor_locked = accept | r_anchor_known;
            end
        end else if (is_packet) begin
            // first packet of the event
            n_pkts         = pkts_inc;
            n_event_anchor = i_item.packet_time;
            o_result.action     = ACT_ARM_IFS;
            o_result.match_time = i_item.now + {{(TimeW-IfsW){1'b0}}, i_cfg.gap_wait};
        end else begin
            // timer match opens the event
            n_event_open = 1'b1;
            o_result.action     = ACT_OPEN_HOP;
            o_result.match_time = i_item.now
                                + {{(TimeW-WindowW){1'b0}}, i_cfg.open_window};
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_anchor  <= '0;
            r_anchor_known <= 1'b0;
            r_last_pkt     <= '0;
            r_event_count  <= '0;
            r_pkts         <= PKT_NONE;
            r_event_anchor <= '0;
            r_event_open   <= 1'b0;
        end else if (i_advance) begin
            r_last_anchor  <= n_last_anchor;
            r_anchor_known <= n_anchor_known;
            r_last_pkt     <= n_last_pkt;
            r_event_count  <= n_event_count;
            r_pkts         <= n_pkts;
            r_event_anchor <= n_event_anchor;
            r_event_open   <= n_event_open;
        end
    end

endmodule

// ===== design/connection_anchor_tracker_top.sv =====
// ----------------------------------------------------------------------------
// connection_anchor_tracker_top - connection event timing tracker
// Follows the anchor points of a low-energy link from packet-end and
// timer-match events and returns the next timer match for each one.
// ----------------------------------------------------------------------------
// Usage:
//   i_in_chan carries one event per transaction: a packet end (mode 0, with
//   the packet start time) or a timer match (mode 1), plus the current time.
//   o_out_chan returns exactly one result transaction per event: the action,
//   the next timer match time, the event counter and the anchor lock flag.
//   The APB port holds the six timing registers; write them while idle.
//   The event lands in the input register, the update logic runs on it and
//   the result lands in the output register, updating the link state at
//   the same edge. Throughput is one event per cycle while the receiver
//   does not stall; each event uses the state the previous one left.
//   When the receiver stalls, the result holds and one more event may wait
//   in the input register; i_in_chan.ready drops only when both are full.
//   Reset clears the link state and restores the register defaults.
// ----------------------------------------------------------------------------
module connection_anchor_tracker_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cat_in_if.sink      i_in_chan,
    cat_out_if.source   o_out_chan,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cat_pkg::*;

    t_cfg     cfg;
    t_in_item r_in_item;
    logic     r_in_valid;
    t_result  result;
    t_result  r_out;
    logic     r_out_valid;
    logic     advance;
    logic     in_take;

    cat_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    cat_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in_item),
        .i_cfg     (cfg),
        .o_result  (result)
    );

    // handshake
    assign advance         = r_in_valid & (~r_out_valid | o_out_chan.ready);
    assign i_in_chan.ready = ~r_in_valid | advance;
    assign in_take         = i_in_chan.valid & i_in_chan.ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item.mode           <= i_in_chan.mode;
            r_in_item.packet_time    <= i_in_chan.packet_time;
            r_in_item.now            <= i_in_chan.now;
            r_in_item.cancel_request <= i_in_chan.cancel_request;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out_chan.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_chan.valid         = r_out_valid;
    assign o_out_chan.action        = r_out.action;
    assign o_out_chan.match_time    = r_out.match_time;
    assign o_out_chan.event_counter = r_out.event_counter;
    assign o_out_chan.anchor_locked = r_out.anchor_locked;

    // checks
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_chan.ready |-> (r_in_valid && r_out_valid && !o_out_chan.ready))
        else $error("input stalled while pipeline has room");

    a_advance_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("advanced event produced no result");

    a_drop_clears_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.action == ACT_LINK_DROP) |->
        (r_out.match_time == '0 && r_out.event_counter == '0 && !r_out.anchor_locked))
        else $error("dropped link result carries stale timing");

endmodule
